[sv/fill_or_kill_order_matcher_core_defines.svh]
// Assertion macros for the fill-or-kill order matcher.
// Used by the top level; no other dependencies.
`ifndef FILL_OR_KILL_ORDER_MATCHER_CORE_DEFINES_SVH
`define FILL_OR_KILL_ORDER_MATCHER_CORE_DEFINES_SVH
// assert that an antecedent implies a consequent in the same cycle
`define FOK_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// assert that an antecedent implies a consequent in the next cycle
`define FOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[sv/fokm_pkg.sv]
// Shared types and constants for the fill-or-kill order matcher.
// No dependencies.
package fokm_pkg;
   localparam int BOOK_DEPTH = 16;
   localparam int IDX_W = $clog2(BOOK_DEPTH);
   localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

   localparam logic [1:0] CMD_LOAD_ASK = 2'd0;
   localparam logic [1:0] CMD_LOAD_BID = 2'd1;
   localparam logic [1:0] CMD_MATCH = 2'd2;

   localparam logic [1:0] ST_TRADE = 2'd0;
   localparam logic [1:0] ST_ZERO_QTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_EXEC, S_EMIT, S_SHIFT, S_STATUS
   } state_type;

   typedef struct packed {
      logic [31:0] price;
      logic [23:0] qty;
      logic [31:0] ident;
   } entry_type;

   typedef struct packed {
      logic              wr;
      logic [IDX_W-1:0]  addr;
      entry_type         data;
   } book_wr_type;
endpackage

[sv/fokm_book.sv]
// One side of the order book: a register-array memory with registered read.
// Depends on fokm_pkg.
module fokm_book (
   input  logic                         clock,
   input  fokm_pkg::book_wr_type        wr,
   input  logic [fokm_pkg::IDX_W-1:0]   rd_addr,
   output fokm_pkg::entry_type          rd_data
);
   fokm_pkg::entry_type mem [fokm_pkg::BOOK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.wr) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[sv/fill_or_kill_order_matcher_core.sv]
// Fill-or-kill order matcher top level: sequencer, both book sides, result register.
// Depends on fokm_pkg, fokm_book and fill_or_kill_order_matcher_core_defines.svh.
// A load or an ignored item is done when it is taken; a status item goes through S_STATUS before
// its result is offered. A match first checks entries until its quantity is covered, then trades
// entry by entry, and when a filled entry is removed the entries behind it are moved down. Each
// book side has one read port and one write port and is read one entry per cycle, and the
// sequencer handles one item at a time; a trade also waits while the previous result is still
// held. req_ready is low while an item is at work or a result waits.
`include "fill_or_kill_order_matcher_core_defines.svh"
module fill_or_kill_order_matcher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic        req_order_side,
   input  logic        req_is_market,
   input  logic [31:0] req_price_ticks,
   input  logic [23:0] req_quantity,
   input  logic [31:0] req_order_ident,
   input  logic [63:0] req_time_stamp,
   input  logic [7:0]  req_strategy_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_trade_ident,
   output logic [63:0] rsp_trade_time,
   output logic [31:0] rsp_resting_ident,
   output logic [31:0] rsp_aggressor_ident,
   output logic        rsp_aggressor_side,
   output logic [31:0] rsp_exec_price,
   output logic [23:0] rsp_traded_qty,
   output logic [7:0]  rsp_trade_tag,
   output logic        rsp_resting_filled,
   output logic [23:0] rsp_total_filled,
   output logic        rsp_last_of_run
);
   localparam int IW = fokm_pkg::IDX_W;
   localparam int CW = fokm_pkg::CNT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(fokm_pkg::BOOK_DEPTH);

   fokm_pkg::state_type state_ff, state_in;
   logic [CW-1:0] ask_cnt_ff, ask_cnt_in, bid_cnt_ff, bid_cnt_in;
   logic [31:0] trade_cnt_ff, trade_cnt_in;
   logic [31:0] last_price_ff, last_price_in;
   logic [23:0] last_total_ff, last_total_in;

   // latched order
   logic        side_ff, side_in, mkt_ff, mkt_in;
   logic [31:0] price_ff, price_in, ident_ff, ident_in;
   logic [23:0] qty_ff, qty_in;
   logic [63:0] stamp_ff, stamp_in;
   logic [7:0]  tag_ff, tag_in;

   // iteration
   logic [CW-1:0] idx_ff, idx_in, mv_ff, mv_in;
   logic [24:0]   sum_ff, sum_in;
   logic [23:0]   rem_ff, rem_in, tot_ff, tot_in;
   logic          rd_wait_ff, rd_wait_in;
   logic [1:0]    code_ff, code_in;

   // result register
   logic        rv_ff, rv_in, rfill_ff, rfill_in, rlast_ff, rlast_in;
   logic [1:0]  rst_ff, rst_in;
   logic [31:0] rtid_ff, rtid_in, rrid_ff, rrid_in, rpx_ff, rpx_in;
   logic [23:0] rqx_ff, rqx_in, rtot_ff, rtot_in;

   fokm_pkg::book_wr_type ask_wr, bid_wr;
   logic [IW-1:0] rd_addr;
   fokm_pkg::entry_type ask_rd, bid_rd, ent;

   fokm_book u_ask (.clock(clock), .wr(ask_wr), .rd_addr(rd_addr), .rd_data(ask_rd));
   fokm_book u_bid (.clock(clock), .wr(bid_wr), .rd_addr(rd_addr), .rd_data(bid_rd));

   logic [CW-1:0] cnt;
   logic          elig;
   logic [23:0]   ex;
   logic [23:0]   new_q;

   always_comb begin
      ent = side_ff ? bid_rd : ask_rd;
      cnt = side_ff ? bid_cnt_ff : ask_cnt_ff;
      elig = mkt_ff || (side_ff ? (ent.price >= price_ff) : (ent.price <= price_ff));
      ex = (ent.qty < rem_ff) ? ent.qty : rem_ff;
      new_q = ent.qty - ex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fokm_pkg::S_IDLE;
         ask_cnt_ff <= '0;
         bid_cnt_ff <= '0;
         trade_cnt_ff <= '0;
         last_price_ff <= '0;
         last_total_ff <= '0;
         rv_ff <= 1'b0;
         rd_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ask_cnt_ff <= ask_cnt_in;
         bid_cnt_ff <= bid_cnt_in;
         trade_cnt_ff <= trade_cnt_in;
         last_price_ff <= last_price_in;
         last_total_ff <= last_total_in;
         rv_ff <= rv_in;
         rd_wait_ff <= rd_wait_in;
      end
      side_ff <= side_in;  mkt_ff <= mkt_in;  price_ff <= price_in;
      ident_ff <= ident_in; qty_ff <= qty_in;  stamp_ff <= stamp_in;
      tag_ff <= tag_in;    idx_ff <= idx_in;  mv_ff <= mv_in;
      sum_ff <= sum_in;    rem_ff <= rem_in;  tot_ff <= tot_in;
      code_ff <= code_in;
      rst_ff <= rst_in;    rtid_ff <= rtid_in; rrid_ff <= rrid_in;
      rpx_ff <= rpx_in;    rqx_ff <= rqx_in;  rtot_ff <= rtot_in;
      rfill_ff <= rfill_in; rlast_ff <= rlast_in;
   end

   always_comb begin
      state_in = state_ff;
      ask_cnt_in = ask_cnt_ff;  bid_cnt_in = bid_cnt_ff;
      trade_cnt_in = trade_cnt_ff;
      last_price_in = last_price_ff; last_total_in = last_total_ff;
      side_in = side_ff;  mkt_in = mkt_ff;  price_in = price_ff;
      ident_in = ident_ff; qty_in = qty_ff; stamp_in = stamp_ff; tag_in = tag_ff;
      idx_in = idx_ff;  mv_in = mv_ff;  sum_in = sum_ff;
      rem_in = rem_ff;  tot_in = tot_ff; rd_wait_in = 1'b0; code_in = code_ff;
      rv_in = rv_ff && !rsp_ready;
      rst_in = rst_ff; rtid_in = rtid_ff; rrid_in = rrid_ff; rpx_in = rpx_ff;
      rqx_in = rqx_ff; rtot_in = rtot_ff; rfill_in = rfill_ff; rlast_in = rlast_ff;
      ask_wr = '0;
      bid_wr = '0;
      rd_addr = idx_ff[IW-1:0];
      req_ready = 1'b0;

      case (state_ff)
         fokm_pkg::S_IDLE: begin
            req_ready = !rv_ff;
            if (req_valid && req_ready) begin
               side_in = req_order_side; mkt_in = req_is_market;
               price_in = req_price_ticks; qty_in = req_quantity;
               ident_in = req_order_ident; stamp_in = req_time_stamp;
               tag_in = req_strategy_tag;
               idx_in = '0; sum_in = '0; rem_in = req_quantity; tot_in = '0;
               rd_wait_in = 1'b1;
               if (req_command == fokm_pkg::CMD_LOAD_ASK ||
                   req_command == fokm_pkg::CMD_LOAD_BID) begin
                  if (req_quantity == '0) begin
                     code_in = fokm_pkg::ST_ZERO_QTY;
                     state_in = fokm_pkg::S_STATUS;
                  end else if (req_command == fokm_pkg::CMD_LOAD_ASK) begin
                     if (ask_cnt_ff >= DEPTH_C) begin
                        code_in = fokm_pkg::ST_FULL;
                        state_in = fokm_pkg::S_STATUS;
                     end else begin
                        ask_wr.wr = 1'b1;
                        ask_wr.addr = ask_cnt_ff[IW-1:0];
                        ask_wr.data = '{req_price_ticks, req_quantity, req_order_ident};
                        ask_cnt_in = ask_cnt_ff + 1'b1;
                     end
                  end else begin
                     if (bid_cnt_ff >= DEPTH_C) begin
                        code_in = fokm_pkg::ST_FULL;
                        state_in = fokm_pkg::S_STATUS;
                     end else begin
                        bid_wr.wr = 1'b1;
                        bid_wr.addr = bid_cnt_ff[IW-1:0];
                        bid_wr.data = '{req_price_ticks, req_quantity, req_order_ident};
                        bid_cnt_in = bid_cnt_ff + 1'b1;
                     end
                  end
               end else if (req_command == fokm_pkg::CMD_MATCH) begin
                  if (req_quantity == '0) begin
                     code_in = fokm_pkg::ST_ZERO_QTY;
                     state_in = fokm_pkg::S_STATUS;
                  end else begin
                     state_in = fokm_pkg::S_CHECK;
                  end
               end
            end
         end
         fokm_pkg::S_STATUS: begin
            if (!rv_ff) begin
               rv_in = 1'b1; rst_in = code_ff;
               rtid_in = '0; rrid_in = '0; rpx_in = '0; rqx_in = '0; rtot_in = '0;
               rfill_in = 1'b0; rlast_in = 1'b1;
               state_in = fokm_pkg::S_IDLE;
            end
         end
         // wait for the registered read, then add
         fokm_pkg::S_CHECK: begin
            if (!rd_wait_ff) begin
               if (idx_ff >= cnt || !elig) begin
                  state_in = fokm_pkg::S_IDLE;
               end else if (sum_ff + 25'(ent.qty) >= 25'(qty_ff)) begin
                  idx_in = '0;
                  rd_wait_in = 1'b1;
                  state_in = fokm_pkg::S_EXEC;
               end else begin
                  sum_in = sum_ff + 25'(ent.qty);
                  idx_in = idx_ff + 1'b1;
                  rd_wait_in = 1'b1;
               end
            end
         end
         fokm_pkg::S_EXEC: begin
            if (!rd_wait_ff && !rv_ff) begin
               rv_in = 1'b1; rst_in = fokm_pkg::ST_TRADE;
               rtid_in = trade_cnt_ff; rrid_in = ent.ident; rpx_in = ent.price;
               rqx_in = ex; rtot_in = tot_ff + ex;
               rfill_in = (new_q == '0);
               rlast_in = (rem_ff == ex);
               tot_in = tot_ff + ex;
               rem_in = rem_ff - ex;
               trade_cnt_in = trade_cnt_ff + 1'b1;
               last_price_in = ent.price;
               if (rem_ff == ex) begin
                  last_total_in = tot_ff + ex;
               end
               if (new_q == '0) begin
                  mv_in = idx_ff;
                  rd_addr = IW'(idx_ff + 1'b1);
                  state_in = fokm_pkg::S_SHIFT;
                  rd_wait_in = 1'b1;
                  if (side_ff) bid_cnt_in = bid_cnt_ff - 1'b1;
                  else ask_cnt_in = ask_cnt_ff - 1'b1;
               end else begin
                  if (side_ff) begin
                     bid_wr.wr = 1'b1; bid_wr.addr = idx_ff[IW-1:0];
                     bid_wr.data = '{ent.price, new_q, ent.ident};
                  end else begin
                     ask_wr.wr = 1'b1; ask_wr.addr = idx_ff[IW-1:0];
                     ask_wr.data = '{ent.price, new_q, ent.ident};
                  end
                  state_in = fokm_pkg::S_IDLE;
               end
            end
         end
         // move entry mv+1 down to mv, one entry per registered read, until the tail
         fokm_pkg::S_SHIFT: begin
            rd_addr = IW'(mv_ff + 1'b1);
            if (!rd_wait_ff) begin
               if (mv_ff >= cnt) begin
                  if (rem_ff == '0) begin
                     state_in = fokm_pkg::S_IDLE;
                  end else begin
                     rd_addr = idx_ff[IW-1:0];
                     rd_wait_in = 1'b1;
                     state_in = fokm_pkg::S_EXEC;
                  end
               end else begin
                  if (side_ff) begin
                     bid_wr.wr = 1'b1; bid_wr.addr = mv_ff[IW-1:0]; bid_wr.data = ent;
                  end else begin
                     ask_wr.wr = 1'b1; ask_wr.addr = mv_ff[IW-1:0]; ask_wr.data = ent;
                  end
                  mv_in = mv_ff + 1'b1;
                  rd_addr = IW'(mv_ff + 2'd2);
                  rd_wait_in = 1'b1;
               end
            end
         end
         default: state_in = fokm_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rst_ff;
   assign rsp_trade_ident = rtid_ff;
   assign rsp_trade_time = (rst_ff == fokm_pkg::ST_TRADE) ? stamp_ff : '0;
   assign rsp_resting_ident = rrid_ff;
   assign rsp_aggressor_ident = (rst_ff == fokm_pkg::ST_TRADE) ? ident_ff : '0;
   assign rsp_aggressor_side = (rst_ff == fokm_pkg::ST_TRADE) ? side_ff : 1'b0;
   assign rsp_exec_price = rpx_ff;
   assign rsp_traded_qty = rqx_ff;
   assign rsp_trade_tag = (rst_ff == fokm_pkg::ST_TRADE) ? tag_ff : '0;
   assign rsp_resting_filled = rfill_ff;
   assign rsp_total_filled = rtot_ff;
   assign rsp_last_of_run = rlast_ff;

   logic        ready_ok;
   logic        rsp_load;
   logic        trade_load;
   logic [31:0] trade_step;

   assign ready_ok = (state_ff == fokm_pkg::S_IDLE) && !rv_ff;
   assign rsp_load = rv_in && !(rv_ff && !rsp_ready);
   assign trade_load = rsp_load && (rst_in == fokm_pkg::ST_TRADE);
   assign trade_step = trade_cnt_ff + 32'd1;

   `FOK_ASSERT_IMP(a_ask_bound, clock, reset, 1'b1, ask_cnt_ff <= DEPTH_C, "ask count over depth")
   `FOK_ASSERT_IMP(a_bid_bound, clock, reset, 1'b1, bid_cnt_ff <= DEPTH_C, "bid count over depth")
   `FOK_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, ready_ok, "ready while busy")
   `FOK_ASSERT_IMP(a_trade_cnt, clock, reset, trade_load, trade_cnt_in == trade_step, "trade cnt")
   `FOK_ASSERT_NEXT(a_rsp_load, clock, reset, rsp_load, rv_ff, "result not offered")
endmodule

[verif/testbench.sv]
// Testbench for the fill-or-kill order matcher: random and directed book loads and matches.
// Predicts trades with a local book model in a scoreboard class; depends on fokm_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_IGNORED = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] trade_ident;
      logic [63:0] trade_time;
      logic [31:0] resting_ident;
      logic [31:0] aggressor_ident;
      logic        aggressor_side;
      logic [31:0] exec_price;
      logic [23:0] traded_qty;
      logic [7:0]  trade_tag;
      logic        resting_filled;
      logic [23:0] total_filled;
      logic        last_of_run;
   } fill_type;

   typedef struct packed {
      logic [1:0]  command;
      logic        side;
      logic        market;
      logic [31:0] price;
      logic [23:0] qty;
      logic [31:0] ident;
      logic [63:0] stamp;
      logic [7:0]  tag;
   } order_type;

   class fill_scoreboard;
      fokm_pkg::entry_type asks[$];
      fokm_pkg::entry_type bids[$];
      logic [31:0] trade_no;
      fill_type    pending_fills[$];
      int          mismatches;

      function new();
         trade_no = 0;
         mismatches = 0;
      endfunction

      function void push_status(logic [1:0] code);
         fill_type f;
         f = '0;
         f.status = code;
         f.last_of_run = 1'b1;
         pending_fills = {pending_fills, f};
      endfunction

      function bit eligible(order_type o, fokm_pkg::entry_type e);
         return o.market || (o.side == 1'b0 ? e.price <= o.price : e.price >= o.price);
      endfunction

      function void note_order(order_type o);
         fokm_pkg::entry_type book[$];
         fokm_pkg::entry_type e;
         logic [31:0] sum;
         logic [23:0] rem;
         logic [23:0] total;
         logic [23:0] ex;
         bit          covered;
         fill_type    f;
         int          i;
         int          n;
         if (o.command == CMD_IGNORED) return;
         if (o.command != fokm_pkg::CMD_MATCH) begin
            e = '{o.price, o.qty, o.ident};
            if (o.qty == 0) begin
               push_status(fokm_pkg::ST_ZERO_QTY);
            end else if ((o.command == fokm_pkg::CMD_LOAD_ASK ? asks.size() : bids.size())
                         >= fokm_pkg::BOOK_DEPTH) begin
               push_status(fokm_pkg::ST_FULL);
            end else if (o.command == fokm_pkg::CMD_LOAD_ASK) begin
               asks = {asks, e};
            end else begin
               bids = {bids, e};
            end
            return;
         end
         if (o.qty == 0) begin
            push_status(fokm_pkg::ST_ZERO_QTY);
            return;
         end
         if (o.side == 1'b0) book = asks;
         else book = bids;
         sum = 0;
         covered = 0;
         for (i = 0; i < book.size(); i++) begin
            if (!eligible(o, book[i])) break;
            sum = sum + 32'(book[i].qty);
            if (sum >= 32'(o.qty)) begin
               covered = 1;
               break;
            end
         end
         if (!covered) return;
         rem = o.qty;
         total = 0;
         n = 0;
         i = 0;
         while (i < book.size() && rem > 0) begin
            if (!eligible(o, book[i])) break;
            ex = (book[i].qty < rem) ? book[i].qty : rem;
            total += ex;
            f = '0;
            f.status = fokm_pkg::ST_TRADE;
            f.trade_ident = trade_no;
            f.trade_time = o.stamp;
            f.resting_ident = book[i].ident;
            f.aggressor_ident = o.ident;
            f.aggressor_side = o.side;
            f.exec_price = book[i].price;
            f.traded_qty = ex;
            f.trade_tag = o.tag;
            f.total_filled = total;
            trade_no++;
            rem -= ex;
            book[i].qty -= ex;
            if (book[i].qty == 0) begin
               f.resting_filled = 1'b1;
               book.delete(i);
            end else begin
               i++;
            end
            pending_fills = {pending_fills, f};
            n++;
         end
         if (n > 0) pending_fills[pending_fills.size() - 1].last_of_run = 1'b1;
         if (o.side == 1'b0) asks = book;
         else bids = book;
      endfunction

      function void check_fill(fill_type got);
         fill_type want;
         if (pending_fills.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %p", got);
            return;
         end
         want = pending_fills.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p\n  actual %p", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic        req_order_side = 1'b0;
   logic        req_is_market = 1'b0;
   logic [31:0] req_price_ticks = '0;
   logic [23:0] req_quantity = '0;
   logic [31:0] req_order_ident = '0;
   logic [63:0] req_time_stamp = '0;
   logic [7:0]  req_strategy_tag = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_trade_ident;
   logic [63:0] rsp_trade_time;
   logic [31:0] rsp_resting_ident;
   logic [31:0] rsp_aggressor_ident;
   logic        rsp_aggressor_side;
   logic [31:0] rsp_exec_price;
   logic [23:0] rsp_traded_qty;
   logic [7:0]  rsp_trade_tag;
   logic        rsp_resting_filled;
   logic [23:0] rsp_total_filled;
   logic        rsp_last_of_run;
   fill_type    rsp;
   fill_scoreboard fills = new();
   bit          long_hold = 1'b0;
   bit          hold_taken = 1'b0;
   int          hold_off = 0;
   int          stall_mode = 0;

   fill_or_kill_order_matcher_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_order_side(req_order_side),
      .req_is_market(req_is_market), .req_price_ticks(req_price_ticks),
      .req_quantity(req_quantity), .req_order_ident(req_order_ident),
      .req_time_stamp(req_time_stamp), .req_strategy_tag(req_strategy_tag),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_trade_ident(rsp_trade_ident),
      .rsp_trade_time(rsp_trade_time), .rsp_resting_ident(rsp_resting_ident),
      .rsp_aggressor_ident(rsp_aggressor_ident),
      .rsp_aggressor_side(rsp_aggressor_side), .rsp_exec_price(rsp_exec_price),
      .rsp_traded_qty(rsp_traded_qty), .rsp_trade_tag(rsp_trade_tag),
      .rsp_resting_filled(rsp_resting_filled), .rsp_total_filled(rsp_total_filled),
      .rsp_last_of_run(rsp_last_of_run)
   );

   assign rsp = {rsp_status, rsp_trade_ident, rsp_trade_time, rsp_resting_ident,
                 rsp_aggressor_ident, rsp_aggressor_side, rsp_exec_price, rsp_traded_qty,
                 rsp_trade_tag, rsp_resting_filled, rsp_total_filled, rsp_last_of_run};

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) fills.check_fill(rsp);
   end

   // receiver stall pattern: free, mostly ready, half ready, with one long hold on request
   always @(posedge clock) begin
      if (long_hold && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_off <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 1) == 0);
         endcase
         if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      end
   end

   task automatic send_order(order_type o);
      req_valid <= 1'b1;
      req_command <= o.command;
      req_order_side <= o.side;
      req_is_market <= o.market;
      req_price_ticks <= o.price;
      req_quantity <= o.qty;
      req_order_ident <= o.ident;
      req_time_stamp <= o.stamp;
      req_strategy_tag <= o.tag;
      do @(posedge clock); while (!req_ready);
      fills.note_order(o);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic order_type make_order(logic [1:0] cmd, logic side, logic mkt,
                                            logic [31:0] price, logic [23:0] qty);
      order_type o;
      o.command = cmd;
      o.side = side;
      o.market = mkt;
      o.price = price;
      o.qty = qty;
      o.ident = $urandom;
      o.stamp = {$urandom, $urandom};
      o.tag = 8'($urandom);
      return o;
   endfunction

   function automatic order_type random_order();
      order_type o;
      int pick;
      pick = $urandom_range(0, 19);
      o = make_order(pick < 8 ? fokm_pkg::CMD_LOAD_ASK : pick < 14 ? fokm_pkg::CMD_LOAD_BID :
                     pick < 19 ? fokm_pkg::CMD_MATCH : CMD_IGNORED,
                     1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0,
                     ($urandom_range(0, 9) == 0) ? $urandom :
                     32'd1000 + $urandom_range(0, 20),
                     ($urandom_range(0, 15) == 0) ? 24'd0 :
                     ($urandom_range(0, 19) == 0) ? 24'($urandom) :
                     24'($urandom_range(1, 60)));
      return o;
   endfunction

   task automatic send_burst(int count);
      int left;
      left = count;
      while (left > 0) begin
         int burst;
         burst = $urandom_range(1, 8);
         while (burst > 0 && left > 0) begin
            send_order(random_order());
            burst--;
            left--;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
      end
   endtask

   initial begin
      int waited;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, zero quantities, full book, ignored command, market and limit
      send_order(make_order(fokm_pkg::CMD_LOAD_ASK, 1'b0, 1'b0, 32'h0, 24'd0));
      send_order(make_order(fokm_pkg::CMD_MATCH, 1'b0, 1'b1, 32'h0, 24'd0));
      send_order(make_order(CMD_IGNORED, 1'b1, 1'b1, '1, '1));
      for (int k = 0; k < 17; k++)
         send_order(make_order(fokm_pkg::CMD_LOAD_ASK, 1'b0, 1'b0,
                               k == 0 ? 32'h0 : 32'd100 + 32'(k),
                               k == 1 ? 24'hFFFFFF : 24'd5));
      send_order(make_order(fokm_pkg::CMD_MATCH, 1'b0, 1'b0, 32'd0, 24'd6));
      send_order(make_order(fokm_pkg::CMD_MATCH, 1'b0, 1'b0, 32'd103, 24'd5));
      send_order(make_order(fokm_pkg::CMD_LOAD_BID, 1'b1, 1'b1, '1, 24'd7));
      send_order(make_order(fokm_pkg::CMD_MATCH, 1'b1, 1'b0, '1, 24'd7));
      send_order(make_order(fokm_pkg::CMD_MATCH, 1'b1, 1'b1, '0, 24'd8));
      send_order(make_order(fokm_pkg::CMD_MATCH, 1'b0, 1'b1, '1, 24'hFFFFFF));
      // one big market buy against the ask book, more than the book holds, so it is killed
      send_order(make_order(fokm_pkg::CMD_MATCH, 1'b0, 1'b1, 32'd0, 24'hFFFFFF));
      send_burst(50);
      // long receiver hold while the sender keeps pushing
      long_hold <= 1'b1;
      send_burst(30);
      send_burst(50);
      req_valid <= 1'b0;
      waited = 0;
      while (fills.pending_fills.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (fills.mismatches == 0 && fills.pending_fills.size() == 0)
         $display("fill_or_kill_order_matcher_core: match");
      else
         $display("fill_or_kill_order_matcher_core: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("fill_or_kill_order_matcher_core: mismatch");
      $finish;
   end
endmodule
